// ===== rtl/core/roi_min_max_mean_stats_core_assert.svh =====
// ----------------------------------------------------------------------------
// roi statistics assertion macros
// shared concurrent check forms for the roi statistics core
// ----------------------------------------------------------------------------
`ifndef ROI_MIN_MAX_MEAN_STATS_CORE_ASSERT_SVH
`define ROI_MIN_MAX_MEAN_STATS_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define ROIMMS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("roimms: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define ROIMMS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("roimms: next-cycle check failed");

`endif

// ===== rtl/core/roimms_pkg.sv =====
// ----------------------------------------------------------------------------
// roimms_pkg
// types and constants shared by the roi statistics core
// ----------------------------------------------------------------------------
package roimms_pkg;

	localparam int MAX_DIM = 4096;
	localparam int REG_W   = 13;
	localparam int COORD_W = $clog2(MAX_DIM);
	localparam int VAL_W   = 16;
	localparam int SUM_W   = 40;
	localparam int CNT_W   = 25;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [REG_W-1:0] DIM_LIM = REG_W'(MAX_DIM);

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BOUNDS = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_SHORT  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_REGION_LEFT   = 3'd2,
		REG_REGION_TOP    = 3'd3,
		REG_REGION_WIDTH  = 3'd4,
		REG_REGION_HEIGHT = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		BK_ACC,
		BK_FIN,
		BK_DIV,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [REG_W-1:0] image_width;
		logic [REG_W-1:0] image_height;
		logic [REG_W-1:0] region_left;
		logic [REG_W-1:0] region_top;
		logic [REG_W-1:0] region_width;
		logic [REG_W-1:0] region_height;
	} cfg_t;

	// one classified pixel on its way from front to back
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [COORD_W-1:0]      col;
		logic [COORD_W-1:0]      row;
		logic                    in_roi;
		logic                    fend;
		status_t                 pre_status;
	} req_t;

endpackage

// ===== rtl/core/roimms_div.sv =====
// ----------------------------------------------------------------------------
// roimms_div
// restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module roimms_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [roimms_pkg::SUM_W-1:0]  dividend,
	input  logic [roimms_pkg::CNT_W-1:0]         divisor,
	output logic                                 busy,
	output logic                                 done,
	output logic signed [roimms_pkg::VAL_W-1:0]  quotient
);
	import roimms_pkg::*;

	localparam int STEP_W = $clog2(SUM_W);

	logic [SUM_W-1:0]  mag_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W:0]    rem_sh;
	logic              fits;
	logic [VAL_W-1:0]  q_lo;

	assign rem_sh = {rem_q, mag_q[SUM_W-1]};
	assign fits   = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == STEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_W-1];
			mag_q <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// quotient bits shift in where dividend bits shift out
			rem_q <= fits ? CNT_W'(rem_sh - {1'b0, dsr_q}) : rem_sh[CNT_W-1:0];
			mag_q <= {mag_q[SUM_W-2:0], fits};
		end
	end

	assign q_lo     = mag_q[VAL_W-1:0];
	assign quotient = neg_q ? VAL_W'(-q_lo) : q_lo;
	assign busy     = busy_q;
	assign done     = done_q;

endmodule

// ===== rtl/core/roimms_front.sv =====
// ----------------------------------------------------------------------------
// roimms_front
// raster position tracking and pixel classification
// ----------------------------------------------------------------------------
module roimms_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  roimms_pkg::cfg_t                    cfg,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [roimms_pkg::VAL_W-1:0]        s_tdata,
	input  logic                                s_tlast,
	output logic                                push,
	input  logic                                push_ready,
	output roimms_pkg::req_t                    req
);
	import roimms_pkg::*;

	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic               past_end_q;
	logic [REG_W-1:0]   c_ext;
	logic [REG_W-1:0]   r_ext;
	logic [REG_W-1:0]   c_inc;
	logic [REG_W-1:0]   r_inc;
	logic [REG_W:0]     col_hi;
	logic [REG_W:0]     row_hi;
	logic               last;
	logic               in_roi;
	logic               bad_geom;
	status_t            pre;

	always_comb begin
		c_ext  = {1'b0, col_q};
		r_ext  = {1'b0, row_q};
		c_inc  = c_ext + 1'b1;
		r_inc  = r_ext + 1'b1;
		col_hi = {1'b0, cfg.region_left} + {1'b0, cfg.region_width};
		row_hi = {1'b0, cfg.region_top} + {1'b0, cfg.region_height};
		last   = (c_inc == cfg.image_width) && (r_inc == cfg.image_height);
		in_roi = !past_end_q &&
			(c_ext < cfg.image_width) && (r_ext < cfg.image_height) &&
			(c_ext >= cfg.region_left) && ({1'b0, c_ext} < col_hi) &&
			(r_ext >= cfg.region_top) && ({1'b0, r_ext} < row_hi);
		bad_geom = (cfg.image_width == '0) || (cfg.image_width > DIM_LIM) ||
			(cfg.image_height == '0) || (cfg.image_height > DIM_LIM) ||
			(col_hi > {1'b0, cfg.image_width}) || (row_hi > {1'b0, cfg.image_height});
		if (bad_geom) begin
			pre = ST_BOUNDS;
		end else if (past_end_q || !last) begin
			pre = ST_SHORT;
		end else begin
			pre = ST_OK;
		end
	end

	assign s_tready = push_ready;
	assign push     = s_tvalid && push_ready;

	always_comb begin
		req.value      = s_tdata;
		req.col        = col_q;
		req.row        = row_q;
		req.in_roi     = in_roi;
		req.fend       = s_tlast;
		req.pre_status = pre;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			past_end_q <= 1'b0;
		end else if (push) begin
			if (s_tlast) begin
				col_q      <= '0;
				row_q      <= '0;
				past_end_q <= 1'b0;
			end else if (past_end_q || last) begin
				past_end_q <= 1'b1;
			end else if ((c_inc >= cfg.image_width) || (c_inc >= DIM_LIM)) begin
				// end of row, or the counter cannot go further
				if (r_inc >= DIM_LIM) begin
					past_end_q <= 1'b1;
				end else begin
					col_q <= '0;
					row_q <= r_inc[COORD_W-1:0];
				end
			end else begin
				col_q <= c_inc[COORD_W-1:0];
			end
		end
	end

endmodule

// ===== rtl/core/roimms_queue.sv =====
// ----------------------------------------------------------------------------
// roimms_queue
// short request queue between the front and the back
// ----------------------------------------------------------------------------
module roimms_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              push_ready,
	input  roimms_pkg::req_t  push_req,
	output logic              pop_valid,
	input  logic              pop,
	output roimms_pkg::req_t  pop_req
);
	import roimms_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	req_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   cnt_q;

	assign push_ready = cnt_q != (PTR_W+1)'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_req    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/roimms_back.sv =====
// ----------------------------------------------------------------------------
// roimms_back
// region accumulation, end-of-frame status, mean division and result register
// ----------------------------------------------------------------------------
`include "roi_min_max_mean_stats_core_assert.svh"

module roimms_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_pop,
	input  roimms_pkg::req_t  req,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [103:0]      m_tdata
);
	import roimms_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        count_q;
	logic signed [VAL_W-1:0] max_q;
	logic [COORD_W-1:0]      max_col_q;
	logic [COORD_W-1:0]      max_row_q;
	logic signed [VAL_W-1:0] min_q;
	logic [COORD_W-1:0]      min_col_q;
	logic [COORD_W-1:0]      min_row_q;
	logic                    any_q;
	status_t                 pre_q;
	status_t                 status_q;
	status_t                 fin_status;
	logic                    out_valid_q;
	logic [103:0]            out_data_q;

	logic                    out_free;
	logic                    div_start;
	logic                    load_out;
	logic                    div_busy;
	logic                    div_done;
	logic signed [VAL_W-1:0] div_q;
	logic                    max_win;
	logic                    min_win;
	logic                    earlier_max;
	logic                    earlier_min;

	roimms_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign out_free   = !out_valid_q || m_tready;
	assign fin_status = (pre_q != ST_OK) ? pre_q : ((count_q == '0) ? ST_EMPTY : ST_OK);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_ACC: begin
				if (req_valid && req.fend) begin
					state_d = BK_FIN;
				end
			end
			BK_FIN: begin
				state_d = (fin_status == ST_OK) ? BK_DIV : BK_DONE;
			end
			BK_DIV: begin
				if (div_done) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (out_free) begin
					state_d = BK_ACC;
				end
			end
			default: state_d = BK_ACC;
		endcase
	end

	// state outputs
	always_comb begin
		req_pop   = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			BK_ACC:  req_pop   = req_valid;
			BK_FIN:  div_start = fin_status == ST_OK;
			BK_DIV:  ;
			BK_DONE: load_out  = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_ACC;
		end else begin
			state_q <= state_d;
		end
	end

	// ties go to the smaller column, then the smaller row
	always_comb begin
		earlier_max = (req.col < max_col_q) || ((req.col == max_col_q) && (req.row < max_row_q));
		earlier_min = (req.col < min_col_q) || ((req.col == min_col_q) && (req.row < min_row_q));
		max_win = !any_q || (req.value > max_q) || ((req.value == max_q) && earlier_max);
		min_win = !any_q || (req.value < min_q) || ((req.value == min_q) && earlier_min);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			count_q   <= '0;
			max_q     <= '0;
			max_col_q <= '0;
			max_row_q <= '0;
			min_q     <= '0;
			min_col_q <= '0;
			min_row_q <= '0;
			any_q     <= 1'b0;
			pre_q     <= ST_OK;
			status_q  <= ST_OK;
		end else begin
			if (load_out) begin
				sum_q     <= '0;
				count_q   <= '0;
				max_q     <= '0;
				max_col_q <= '0;
				max_row_q <= '0;
				min_q     <= '0;
				min_col_q <= '0;
				min_row_q <= '0;
				any_q     <= 1'b0;
			end else if (req_pop && req.in_roi) begin
				sum_q   <= sum_q + SUM_W'(req.value);
				count_q <= count_q + 1'b1;
				any_q   <= 1'b1;
				if (max_win) begin
					max_q     <= req.value;
					max_col_q <= req.col;
					max_row_q <= req.row;
				end
				if (min_win) begin
					min_q     <= req.value;
					min_col_q <= req.col;
					min_row_q <= req.row;
				end
			end
			if (req_pop && req.fend) begin
				pre_q <= req.pre_status;
			end
			if (state_q == BK_FIN) begin
				status_q <= fin_status;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (status_q == ST_OK) begin
				out_data_q <= {6'd0, min_row_q, min_col_q, min_q, max_row_q, max_col_q,
					max_q, div_q, status_q};
			end else begin
				out_data_q <= {102'd0, status_q};
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	`ROIMMS_ASSERT_IMP(a_div_in_div_state, clk, arst_n, div_busy, state_q == BK_DIV)
	`ROIMMS_ASSERT_IMP(a_any_tracks_count, clk, arst_n, 1'b1, any_q == (count_q != '0))
	`ROIMMS_ASSERT_IMP(a_max_not_below_min, clk, arst_n, any_q, max_q >= min_q)
	`ROIMMS_ASSERT_NXT(a_fin_leaves, clk, arst_n, state_q == BK_FIN, state_q != BK_FIN)

endmodule

// ===== rtl/core/roi_min_max_mean_stats_core.sv =====
// ----------------------------------------------------------------------------
// roi_min_max_mean_stats_core
// region-of-interest min / max / mean statistics over a raster pixel stream
// ----------------------------------------------------------------------------
// pixels enter on the s_ channel in raster order, one per request, tlast on
// the last pixel of the frame. inside the rectangle set over the apb port the
// core keeps sum, count, min and max with their coordinates; each frame_end
// pixel gives exactly one result on the m_ channel (status, mean, max, min).
// a front stage tracks column and row and classifies each pixel, a two-entry
// request queue feeds the back stage that accumulates one pixel per cycle.
// throughput is one pixel per cycle within a frame while the back stage is
// accumulating. an ok result goes through the fin, div and done states to the
// output register, any other status skips div; the mean comes from a 40-step
// one-bit-per-cycle divider; while it runs the back stage takes no pixels,
// so the input stalls after the frame_end of a frame with status ok. a
// finished result waits in its output register while the next frame's pixels
// keep flowing; a second frame_end waits until that register is taken. reset
// clears all frame state and sets a 640x512 image with an empty region. the
// user must write registers only while no frame is in progress; not enforced.
// ----------------------------------------------------------------------------
module roi_min_max_mean_stats_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // [15:0] pixel_value
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [1:0] status, [17:2] mean_value, [33:18] max_value, [45:34] max_col,
	// [57:46] max_row, [73:58] min_value, [85:74] min_col, [97:86] min_row
	output logic [103:0] m_tdata
);
	import roimms_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;
	logic     push;
	logic     push_ready;
	req_t     front_req;
	logic     q_valid;
	logic     q_pop;
	req_t     q_req;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= REG_W'(640);
			cfg_q.image_height  <= REG_W'(512);
			cfg_q.region_left   <= '0;
			cfg_q.region_top    <= '0;
			cfg_q.region_width  <= '0;
			cfg_q.region_height <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= pwdata[REG_W-1:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= pwdata[REG_W-1:0];
				REG_REGION_LEFT:   cfg_q.region_left   <= pwdata[REG_W-1:0];
				REG_REGION_TOP:    cfg_q.region_top    <= pwdata[REG_W-1:0];
				REG_REGION_WIDTH:  cfg_q.region_width  <= pwdata[REG_W-1:0];
				REG_REGION_HEIGHT: cfg_q.region_height <= pwdata[REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH:   prdata = 32'(cfg_q.image_width);
			REG_IMAGE_HEIGHT:  prdata = 32'(cfg_q.image_height);
			REG_REGION_LEFT:   prdata = 32'(cfg_q.region_left);
			REG_REGION_TOP:    prdata = 32'(cfg_q.region_top);
			REG_REGION_WIDTH:  prdata = 32'(cfg_q.region_width);
			REG_REGION_HEIGHT: prdata = 32'(cfg_q.region_height);
			default:           prdata = '0;
		endcase
	end

	roimms_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.push       (push),
		.push_ready (push_ready),
		.req        (front_req)
	);

	roimms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_req   (front_req),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_req    (q_req)
	);

	roimms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (q_valid),
		.req_pop   (q_pop),
		.req       (q_req),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
